[design/hed_pkg.sv]
// Package with constants, types and the entity lookup for the HTML entity decoder.
`timescale 1ns / 1ps
`default_nettype none

package hed_pkg;

    localparam int MaxNameLen = 8;
    localparam int LenW = $clog2(MaxNameLen + 1);
    localparam int IdxW = $clog2(MaxNameLen);
    localparam int CntW = $clog2(MaxNameLen + 3);
    localparam int QDepth = 4;
    localparam int QPtrW = $clog2(QDepth);

    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_SEMI = 8'h3B;

    localparam logic [1:0] MODE_TEXT = 2'd0;
    localparam logic [1:0] MODE_NAME = 2'd1;
    localparam logic [1:0] MODE_SKIP = 2'd2;

    localparam logic [1:0] CMD_BYTE    = 2'd0;
    localparam logic [1:0] CMD_VERB    = 2'd1;
    localparam logic [1:0] CMD_ENTITY  = 2'd2;

    typedef struct packed {
        logic [1:0]                    kind;
        logic [7:0]                    data;
        logic                          last;
        logic [LenW-1:0]               len;
        logic [MaxNameLen-1:0][7:0]    name;
    } t_cmd;

    typedef struct packed {
        logic        hit;
        logic [15:0] code;
    } t_hit;

    function automatic logic [15:0] code_of(input logic [MaxNameLen*8-1:0] s);
        logic [15:0] c;
        c = 16'h0000;
        unique case (s)
            {"AElig"}: c = 16'h00C6;  {"Aacute"}: c = 16'h00C1; {"Acirc"}: c = 16'h00C2;
            {"Agrave"}: c = 16'h00C0; {"Aring"}: c = 16'h00C5;  {"Atilde"}: c = 16'h00C3;
            {"Auml"}: c = 16'h00C4;   {"aacute"}: c = 16'h00E1; {"acute"}: c = 16'h00B4;
            {"acirc"}: c = 16'h00E2;  {"aelig"}: c = 16'h00E6;  {"agrave"}: c = 16'h00E0;
            {"amp"}: c = 16'h0026;    {"apos"}: c = 16'h0027;   {"aring"}: c = 16'h00E5;
            {"atilde"}: c = 16'h00E3; {"auml"}: c = 16'h00E4;   {"brvbar"}: c = 16'h00A6;
            {"Ccedil"}: c = 16'h00C7; {"ccedil"}: c = 16'h00E7; {"cedil"}: c = 16'h00B8;
            {"cent"}: c = 16'h00A2;   {"copy"}: c = 16'h00A9;   {"curren"}: c = 16'h00A4;
            {"deg"}: c = 16'h00B0;    {"divide"}: c = 16'h00F7; {"ETH"}: c = 16'h00D0;
            {"Eacute"}: c = 16'h00C9; {"Ecirc"}: c = 16'h00CA;  {"Egrave"}: c = 16'h00C8;
            {"Euml"}: c = 16'h00CB;   {"eacute"}: c = 16'h00E9; {"ecirc"}: c = 16'h00EA;
            {"egrave"}: c = 16'h00E8; {"eth"}: c = 16'h00F0;    {"euml"}: c = 16'h00EB;
            {"frac12"}: c = 16'h00BD; {"frac14"}: c = 16'h00BC; {"frac34"}: c = 16'h00BE;
            {"gt"}: c = 16'h003E;     {"hellip"}: c = 16'h2026; {"Iacute"}: c = 16'h00CD;
            {"Icirc"}: c = 16'h00CE;  {"Igrave"}: c = 16'h00CC; {"Iuml"}: c = 16'h00CF;
            {"iacute"}: c = 16'h00ED; {"icirc"}: c = 16'h00EE;  {"iexcl"}: c = 16'h00A1;
            {"igrave"}: c = 16'h00EC; {"iuml"}: c = 16'h00EF;   {"iquest"}: c = 16'h00BF;
            {"laquo"}: c = 16'h00AB;  {"lt"}: c = 16'h003C;     {"macr"}: c = 16'h00AF;
            {"micro"}: c = 16'h00B5;  {"middot"}: c = 16'h00B7; {"Ntilde"}: c = 16'h00D1;
            {"nbsp"}: c = 16'h00A0;   {"not"}: c = 16'h00AC;    {"ntilde"}: c = 16'h00F1;
            {"Oacute"}: c = 16'h00D3; {"Ocirc"}: c = 16'h00D4;  {"Ograve"}: c = 16'h00D2;
            {"Oslash"}: c = 16'h00D8; {"Otilde"}: c = 16'h00D5; {"Ouml"}: c = 16'h00D6;
            {"oacute"}: c = 16'h00F3; {"ocirc"}: c = 16'h00F4;  {"ograve"}: c = 16'h00F2;
            {"ordf"}: c = 16'h00AA;   {"ordm"}: c = 16'h00BA;   {"oslash"}: c = 16'h00F8;
            {"otilde"}: c = 16'h00F5; {"ouml"}: c = 16'h00F6;   {"para"}: c = 16'h00B6;
            {"plusmn"}: c = 16'h00B1; {"pound"}: c = 16'h00A3;  {"quot"}: c = 16'h0022;
            {"raquo"}: c = 16'h00BB;  {"reg"}: c = 16'h00AE;    {"sect"}: c = 16'h00A7;
            {"shy"}: c = 16'h00AD;    {"sup1"}: c = 16'h00B9;   {"sup2"}: c = 16'h00B2;
            {"sup3"}: c = 16'h00B3;   {"szlig"}: c = 16'h00DF;  {"THORN"}: c = 16'h00DE;
            {"thorn"}: c = 16'h00FE;  {"times"}: c = 16'h00D7;  {"Uacute"}: c = 16'h00DA;
            {"Ucirc"}: c = 16'h00DB;  {"Ugrave"}: c = 16'h00D9; {"Uuml"}: c = 16'h00DC;
            {"uacute"}: c = 16'h00FA; {"ucirc"}: c = 16'h00FB;  {"ugrave"}: c = 16'h00F9;
            {"uml"}: c = 16'h00A8;    {"uuml"}: c = 16'h00FC;   {"Yacute"}: c = 16'h00DD;
            {"yacute"}: c = 16'h00FD; {"yen"}: c = 16'h00A5;    {"yuml"}: c = 16'h00FF;
            default: c = 16'h0000;
        endcase
        return c;
    endfunction

    // The name is right-aligned and zero-padded so it compares against string literals.
    // A held zero byte would vanish into the padding, so such a name never matches.
    function automatic t_hit lookup(input logic [MaxNameLen-1:0][7:0] name,
                                    input logic [LenW-1:0] len);
        logic [MaxNameLen*8-1:0] s;
        t_hit                    h;
        logic                    nul;
        s = '0;
        nul = 1'b0;
        for (int i = 0; i < MaxNameLen; i++) begin
            if (LenW'(i) < len) begin
                s[(int'(len) - 1 - i) * 8 +: 8] = name[i];
                if (name[i] == 8'h00) nul = 1'b1;
            end
        end
        h.code = code_of(s);
        h.hit = (h.code != 16'h0000) && (len != '0) && !nul;
        return h;
    endfunction

endpackage

`default_nettype wire

[design/hed_front.sv]
// Front end: parses input bytes, collects entity names and issues commands.
`timescale 1ns / 1ps
`default_nettype none

module hed_front import hed_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_last,
    output logic            o_cmd_valid,
    input  wire logic       i_cmd_ready,
    output t_cmd            o_cmd
);

    logic [1:0]                 r_mode, n_mode;
    logic [LenW-1:0]            r_len, n_len;
    logic [MaxNameLen-1:0][7:0] r_name;
    logic                       take;

    assign o_ready = i_cmd_ready;
    assign take = i_valid && i_cmd_ready;

    always_comb begin
        n_mode = r_mode;
        n_len = r_len;
        o_cmd_valid = 1'b0;
        o_cmd.kind = CMD_BYTE;
        o_cmd.data = i_byte;
        o_cmd.last = i_last;
        o_cmd.len = r_len;
        o_cmd.name = r_name;
        if (i_valid) begin
            unique case (r_mode)
                MODE_NAME: begin
                    if (i_byte == CH_SEMI) begin
                        o_cmd.kind = CMD_ENTITY;
                        o_cmd_valid = 1'b1;
                        n_mode = MODE_TEXT;
                        n_len = '0;
                    end else if (r_len >= LenW'(MaxNameLen)) begin
                        o_cmd.kind = CMD_VERB;
                        o_cmd_valid = 1'b1;
                        n_mode = MODE_SKIP;
                        n_len = '0;
                    end else if (i_last) begin
                        o_cmd.kind = CMD_VERB;
                        o_cmd_valid = 1'b1;
                    end else begin
                        n_len = r_len + 1'b1;
                    end
                end
                MODE_SKIP: begin
                    o_cmd_valid = 1'b1;
                    if (i_byte == CH_SEMI) begin
                        n_mode = MODE_TEXT;
                    end
                end
                default: begin
                    if (i_byte == CH_AMP && !i_last) begin
                        n_mode = MODE_NAME;
                        n_len = '0;
                    end else begin
                        o_cmd_valid = 1'b1;
                    end
                end
            endcase
            if (i_last) begin
                n_mode = MODE_TEXT;
                n_len = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_TEXT;
            r_len <= '0;
        end else if (take) begin
            r_mode <= n_mode;
            r_len <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && r_mode == MODE_NAME && r_len < LenW'(MaxNameLen)) begin
            r_name[r_len[IdxW-1:0]] <= i_byte;
        end
    end

endmodule

`default_nettype wire

[design/hed_queue.sv]
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module hed_queue import hed_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_cmd i_cmd,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_cmd      o_cmd
);

    t_cmd               r_mem [QDepth];
    logic [QPtrW-1:0]   r_wr, r_rd;
    logic [QPtrW:0]     r_cnt;
    logic               push, pop;

    assign o_ready = r_cnt != (QPtrW+1)'(QDepth);
    assign o_valid = r_cnt != '0;
    assign o_cmd = r_mem[r_rd];
    assign push = i_valid && o_ready;
    assign pop = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wr <= r_wr + 1'b1;
            if (pop) r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (QPtrW+1)'(push) - (QPtrW+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr] <= i_cmd;
    end

endmodule

`default_nettype wire

[design/hed_back.sv]
// Back end: looks up entity names and emits the decoded output bytes.
`timescale 1ns / 1ps
`default_nettype none

module hed_back import hed_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire t_cmd       i_cmd,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_byte,
    output logic            o_last,
    output logic            o_done
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOOK = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]                     r_st;
    t_cmd                           r_cmd;
    logic                           r_hit;
    logic [15:0]                    r_code;
    logic [CntW-1:0]                r_idx, r_total;
    t_hit                           h;
    logic [7:0]                     cur;
    logic                           fire;

    assign h = lookup(r_cmd.name, r_cmd.len);
    assign o_ready = r_st == ST_IDLE;
    assign o_valid = r_st == ST_EMIT;
    assign fire = o_valid && i_ready;

    always_comb begin
        cur = r_cmd.data;
        if (r_hit) begin
            if (r_total == CntW'(1)) cur = r_code[7:0];
            else if (r_total == CntW'(2)) begin
                cur = (r_idx == '0) ? {3'b110, r_code[10:6]} : {2'b10, r_code[5:0]};
            end else begin
                priority case (r_idx)
                    CntW'(0): cur = {4'b1110, r_code[15:12]};
                    CntW'(1): cur = {2'b10, r_code[11:6]};
                    default:  cur = {2'b10, r_code[5:0]};
                endcase
            end
        end else if (r_cmd.kind != CMD_BYTE) begin
            if (r_idx == '0) cur = CH_AMP;
            else if (r_idx == r_total - 1'b1) cur = r_cmd.data;
            else cur = r_cmd.name[IdxW'(r_idx - 1'b1)];
        end
    end

    assign o_byte = cur;
    assign o_last = r_idx == r_total - 1'b1;
    assign o_done = o_last && r_cmd.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
        end else begin
            unique case (r_st)
                ST_IDLE: if (i_valid) r_st <= ST_LOOK;
                ST_LOOK: r_st <= ST_EMIT;
                ST_EMIT: if (fire && o_last) r_st <= ST_IDLE;
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == ST_IDLE && i_valid) begin
            r_cmd <= i_cmd;
            r_idx <= '0;
        end else if (r_st == ST_LOOK) begin
            r_hit <= (r_cmd.kind == CMD_ENTITY) && h.hit;
            r_code <= h.code;
        end else if (fire) begin
            r_idx <= r_idx + 1'b1;
        end
        if (r_st == ST_LOOK) begin
            if (r_cmd.kind == CMD_BYTE) r_total <= CntW'(1);
            else if (r_cmd.kind == CMD_ENTITY && h.hit) begin
                if (h.code < 16'h0080) r_total <= CntW'(1);
                else if (h.code < 16'h0800) r_total <= CntW'(2);
                else r_total <= CntW'(3);
            end else r_total <= CntW'(r_cmd.len) + CntW'(2);
        end
    end

endmodule

`default_nettype wire

[design/html_entity_decoder_core.sv]
// Top level of the streaming HTML named character reference decoder.
`timescale 1ns / 1ps
`default_nettype none

// Ordinary text bytes are taken one per cycle while the command queue has room;
// each byte that causes output steps the back end through taking the command,
// looking it up and emitting its output bytes, and the back end takes no new
// command until the last output byte is accepted. Name bytes after an ampersand
// are absorbed without output, one per cycle while the command queue has room.
module html_entity_decoder_core import hed_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // in_byte
    input  wire logic       s_axis_tlast,   // end_of_text
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // out_byte
    output logic            m_axis_tlast,   // last_of_run
    output logic            m_axis_tuser    // text_done
);

    t_cmd f_cmd, q_cmd;
    logic f_valid, f_ready, q_valid, q_ready;

    hed_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_byte(s_axis_tdata), .i_last(s_axis_tlast),
        .o_cmd_valid(f_valid), .i_cmd_ready(f_ready), .o_cmd(f_cmd)
    );

    hed_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(f_valid), .o_ready(f_ready), .i_cmd(f_cmd),
        .o_valid(q_valid), .i_ready(q_ready), .o_cmd(q_cmd)
    );

    hed_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .o_ready(q_ready), .i_cmd(q_cmd),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_byte(m_axis_tdata), .o_last(m_axis_tlast), .o_done(m_axis_tuser)
    );

endmodule

`default_nettype wire

[design/hed_checker.sv]
// Port-level checker for the HTML entity decoder and its bind.
`timescale 1ns / 1ps
`default_nettype none

module hed_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       s_axis_tready,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic       m_axis_tlast,
    input wire logic       m_axis_tuser
);

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("text_done without last_of_run");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output transaction changed while stalled");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready)
        else $error("input not ready after reset");

endmodule

bind html_entity_decoder_core hed_checker u_hed_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .m_axis_tuser(m_axis_tuser)
);

`default_nettype wire

[dv/tb_html_entity_decoder_core.sv]
// Testbench for the streaming HTML entity decoder: predicted output checked per transaction.
`timescale 1ns / 1ps

class entity_scoreboard;
    bit [9:0] pending[$];
    int       errors;
    int       matched;
    bit [1:0] mode;
    bit [7:0] held[hed_pkg::MaxNameLen];
    int       held_len;

    function void clear();
        mode = hed_pkg::MODE_TEXT;
        held_len = 0;
        errors = 0;
        matched = 0;
    endfunction

    function bit [15:0] entity_code(string nm);
        case (nm)
            "AElig": return 16'hC6;  "Aacute": return 16'hC1; "Acirc": return 16'hC2;
            "Agrave": return 16'hC0; "Aring": return 16'hC5;  "Atilde": return 16'hC3;
            "Auml": return 16'hC4;   "aacute": return 16'hE1; "acute": return 16'hB4;
            "acirc": return 16'hE2;  "aelig": return 16'hE6;  "agrave": return 16'hE0;
            "amp": return 16'h26;    "apos": return 16'h27;   "aring": return 16'hE5;
            "atilde": return 16'hE3; "auml": return 16'hE4;   "brvbar": return 16'hA6;
            "Ccedil": return 16'hC7; "ccedil": return 16'hE7; "cedil": return 16'hB8;
            "cent": return 16'hA2;   "copy": return 16'hA9;   "curren": return 16'hA4;
            "deg": return 16'hB0;    "divide": return 16'hF7; "ETH": return 16'hD0;
            "Eacute": return 16'hC9; "Ecirc": return 16'hCA;  "Egrave": return 16'hC8;
            "Euml": return 16'hCB;   "eacute": return 16'hE9; "ecirc": return 16'hEA;
            "egrave": return 16'hE8; "eth": return 16'hF0;    "euml": return 16'hEB;
            "frac12": return 16'hBD; "frac14": return 16'hBC; "frac34": return 16'hBE;
            "gt": return 16'h3E;     "hellip": return 16'h2026; "Iacute": return 16'hCD;
            "Icirc": return 16'hCE;  "Igrave": return 16'hCC; "Iuml": return 16'hCF;
            "iacute": return 16'hED; "icirc": return 16'hEE;  "iexcl": return 16'hA1;
            "igrave": return 16'hEC; "iuml": return 16'hEF;   "iquest": return 16'hBF;
            "laquo": return 16'hAB;  "lt": return 16'h3C;     "macr": return 16'hAF;
            "micro": return 16'hB5;  "middot": return 16'hB7; "Ntilde": return 16'hD1;
            "nbsp": return 16'hA0;   "not": return 16'hAC;    "ntilde": return 16'hF1;
            "Oacute": return 16'hD3; "Ocirc": return 16'hD4;  "Ograve": return 16'hD2;
            "Oslash": return 16'hD8; "Otilde": return 16'hD5; "Ouml": return 16'hD6;
            "oacute": return 16'hF3; "ocirc": return 16'hF4;  "ograve": return 16'hF2;
            "ordf": return 16'hAA;   "ordm": return 16'hBA;   "oslash": return 16'hF8;
            "otilde": return 16'hF5; "ouml": return 16'hF6;   "para": return 16'hB6;
            "plusmn": return 16'hB1; "pound": return 16'hA3;  "quot": return 16'h22;
            "raquo": return 16'hBB;  "reg": return 16'hAE;    "sect": return 16'hA7;
            "shy": return 16'hAD;    "sup1": return 16'hB9;   "sup2": return 16'hB2;
            "sup3": return 16'hB3;   "szlig": return 16'hDF;  "THORN": return 16'hDE;
            "thorn": return 16'hFE;  "times": return 16'hD7;  "Uacute": return 16'hDA;
            "Ucirc": return 16'hDB;  "Ugrave": return 16'hD9; "Uuml": return 16'hDC;
            "uacute": return 16'hFA; "ucirc": return 16'hFB;  "ugrave": return 16'hF9;
            "uml": return 16'hA8;    "uuml": return 16'hFC;   "Yacute": return 16'hDD;
            "yacute": return 16'hFD; "yen": return 16'hA5;    "yuml": return 16'hFF;
            default: return 16'h0;
        endcase
    endfunction

    function void note_input(bit [7:0] b, bit eot);
        bit [7:0] outs[$];
        bit [15:0] cp;
        string nm;
        bit has_nul;
        nm = "";
        has_nul = 1'b0;
        if (mode == hed_pkg::MODE_NAME) begin
            if (b == hed_pkg::CH_SEMI) begin
                for (int i = 0; i < held_len; i++) begin
                    if (held[i] == 8'h00) has_nul = 1'b1;
                    nm = {nm, string'(held[i])};
                end
                cp = (held_len == 0 || has_nul) ? 16'h0 : entity_code(nm);
                if (cp == 16'h0) begin
                    outs.push_back(hed_pkg::CH_AMP);
                    for (int i = 0; i < held_len; i++) outs.push_back(held[i]);
                    outs.push_back(b);
                end else if (cp < 16'h80) begin
                    outs.push_back(cp[7:0]);
                end else if (cp < 16'h800) begin
                    outs.push_back(8'hC0 | cp[10:6]);
                    outs.push_back(8'h80 | cp[5:0]);
                end else begin
                    outs.push_back(8'hE0 | cp[15:12]);
                    outs.push_back(8'h80 | cp[11:6]);
                    outs.push_back(8'h80 | cp[5:0]);
                end
                mode = hed_pkg::MODE_TEXT;
                held_len = 0;
            end else if (held_len >= hed_pkg::MaxNameLen || eot) begin
                outs.push_back(hed_pkg::CH_AMP);
                for (int i = 0; i < held_len; i++) outs.push_back(held[i]);
                outs.push_back(b);
                if (!eot) mode = hed_pkg::MODE_SKIP;
                held_len = 0;
            end else begin
                held[held_len] = b;
                held_len++;
            end
        end else if (mode == hed_pkg::MODE_SKIP) begin
            outs.push_back(b);
            if (b == hed_pkg::CH_SEMI) mode = hed_pkg::MODE_TEXT;
        end else if (b == hed_pkg::CH_AMP && !eot) begin
            mode = hed_pkg::MODE_NAME;
            held_len = 0;
        end else begin
            outs.push_back(b);
        end
        if (eot) begin
            mode = hed_pkg::MODE_TEXT;
            held_len = 0;
        end
        foreach (outs[k])
            pending.push_back({outs[k], k == outs.size() - 1, eot && k == outs.size() - 1});
    endfunction

    function void check_output(bit [7:0] d, bit lst, bit done);
        bit [9:0] e;
        if (pending.size() == 0) begin
            $error("unexpected output byte %02h", d);
            errors++;
            return;
        end
        e = pending.pop_front();
        matched++;
        if (e[9:2] != d) begin
            $error("out_byte expected %02h actual %02h", e[9:2], d);
            errors++;
        end
        if (e[1] != lst) begin
            $error("last_of_run expected %0d actual %0d", e[1], lst);
            errors++;
        end
        if (e[0] != done) begin
            $error("text_done expected %0d actual %0d", e[0], done);
            errors++;
        end
    endfunction
endclass

module tb_html_entity_decoder_core;
    import hed_pkg::*;

    logic       i_clk;
    logic       i_rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;   // in_byte
    logic       s_axis_tlast;   // end_of_text
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;   // out_byte
    logic       m_axis_tlast;   // last_of_run
    logic       m_axis_tuser;   // text_done

    entity_scoreboard decode_sb;
    int  burst_left;
    int  hold_off;
    int  items_sent;
    string known_names[$];

    html_entity_decoder_core DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("html_entity_decoder_core: mismatch");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            decode_sb.check_output(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end

    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    task automatic send_byte(input bit [7:0] b, input bit eot);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(1, 12);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eot;
        do @(posedge i_clk); while (!s_axis_tready);
        decode_sb.note_input(b, eot);
        items_sent++;
    endtask

    task automatic send_text(input string s, input bit eot);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], eot && i == s.len() - 1);
    endtask

    function automatic bit [7:0] rand_byte();
        case ($urandom_range(0, 5))
            0: return CH_AMP;
            1: return CH_SEMI;
            2, 3: return 8'($urandom_range(8'h61, 8'h7A));
            default: return 8'($urandom);
        endcase
    endfunction

    initial begin
        string nm;
        decode_sb = new();
        decode_sb.clear();
        known_names = '{"AElig", "amp", "hellip", "iquest", "lt", "yuml", "frac34", "nbsp",
                        "Ograve", "eth", "THORN", "quot", "deg", "szlig"};
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 8'h00;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        hold_off = 0;
        burst_left = 0;
        items_sent = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, matches, misses, empty name, overlong name, open entity.
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_text("&hellip;&AElig;&iquest;&amp;", 1'b0);
        send_text("&;&Amp;", 1'b0);
        send_text("&abcdefghij;x;", 1'b0);
        send_text("&&;", 1'b0);
        send_text("&lt", 1'b1);
        send_text("&", 1'b1);

        // Receiver holds off long while input keeps coming.
        hold_off = 300;
        for (int i = 0; i < 40; i++) send_byte(8'($urandom_range(8'h41, 8'h5A)), 1'b0);
        send_byte(8'h2E, 1'b1);

        // Sender waits for all results to drain.
        s_axis_tvalid <= 1'b0;
        while (decode_sb.pending.size() != 0) @(posedge i_clk);

        while (items_sent < 405) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    nm = known_names[$urandom_range(0, known_names.size() - 1)];
                    send_text({"&", nm, ";"}, 1'b0);
                end
                4: begin
                    send_byte(CH_AMP, 1'b0);
                    repeat ($urandom_range(0, MaxNameLen + 2)) send_byte(rand_byte(), 1'b0);
                    send_byte(CH_SEMI, 1'b0);
                end
                5: send_byte(rand_byte(), 1'b1);
                6: send_byte(8'($urandom), 1'b0);
                default: send_byte(rand_byte(), 1'b0);
            endcase
        end
        send_byte(8'h0A, 1'b1);
        s_axis_tvalid <= 1'b0;

        while (decode_sb.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("Sent %0d bytes with entity hits, misses, overlong names and text ends;",
                 items_sent);
        $display("checked %0d output bytes.", decode_sb.matched);
        if (decode_sb.errors == 0 && decode_sb.pending.size() == 0)
            $display("html_entity_decoder_core: match");
        else
            $display("html_entity_decoder_core: mismatch");
        $finish;
    end
endmodule

[sim.f]
design/hed_pkg.sv
design/hed_front.sv
design/hed_queue.sv
design/hed_back.sv
design/html_entity_decoder_core.sv
design/hed_checker.sv
dv/tb_html_entity_decoder_core.sv
